// ----- hdl/varint_zigzag_codec_macros.svh -----
// Assertion macros for the varint/zigzag codec checker.
// Self-contained; included by the checker file only.
`ifndef VARINT_ZIGZAG_CODEC_MACROS_SVH
`define VARINT_ZIGZAG_CODEC_MACROS_SVH

// Checked only while out of reset.
`define VZZ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define VZZ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/vzz_pkg.sv -----
// Shared types and constants of the varint/zigzag codec.
// No dependencies; imported by every module of the block.
package vzz_pkg;

    localparam logic OP_ENCODE  = 1'b0;
    localparam logic OP_DECODE  = 1'b1;
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    localparam int  GROUP_BITS = 7;
    localparam int  Q_DEPTH    = 2;
    localparam int  Q_PTR_W    = $clog2(Q_DEPTH);

    // Index of the final byte allowed at each width (byte limit minus one).
    localparam logic [3:0] LAST_IDX_NARROW = 4'd4;
    localparam logic [3:0] LAST_IDX_WIDE   = 4'd9;

    typedef struct packed {
        logic        op;
        logic        wide;
        logic        zigzag;
        logic [63:0] value;
        logic [7:0]  in_byte;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  out_byte;
        logic [63:0] out_value;
        logic        last;
    } t_out_item;

    // Classified item: encode carries the mapped value, decode the byte in data[7:0].
    typedef struct packed {
        logic        op;
        logic        wide;
        logic        zigzag;
        logic [63:0] data;
    } t_q_entry;

endpackage

// ----- hdl/varint_zigzag_codec.sv -----
// Top level of the base-128 varint codec with optional zigzag mapping.
// Depends on vzz_pkg, vzz_front, vzz_queue and vzz_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one item per
//   transfer: op selects encode of value or decode of in_byte, wide selects
//   64-bit over 32-bit width, zigzag selects the signed mapping.
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns results:
//   an encode gives 1 to 5 (narrow) or 1 to 10 (wide) byte results, last set
//   on the final one; a decode gives one value result at its final byte.
//   An item's first result comes from the output register, after the queue.
//   Throughput while the output is not stalled: one decode byte per cycle;
//   an encode leaves the back end's single output register one byte a cycle
//   and holds later items in the queue. A two-entry queue decouples the front
//   end, so items keep being taken while a result waits. When the receiver
//   stalls, the output holds, the queue fills and o_in_ready drops.
//   Reset (synchronous, active low) empties the queue, drops any result in
//   flight and clears the decode accumulator and latched width and mode.
module varint_zigzag_codec
    import vzz_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic     w_push;
    t_q_entry w_push_entry;
    logic     w_q_ready;
    logic     w_q_valid;
    t_q_entry w_q_entry;
    logic     w_pop;

    vzz_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_ready  (w_q_ready),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    vzz_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry),
        .i_pop   (w_pop)
    );

    vzz_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_entry   (w_q_entry),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- hdl/vzz_front.sv -----
// Front end: accepts input items, applies width masking and zigzag mapping.
// Depends on vzz_pkg; feeds vzz_queue.
module vzz_front
    import vzz_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    input  logic     i_q_ready,
    output logic     o_push,
    output t_q_entry o_entry
);

    logic [63:0] w_map_wide;
    logic [31:0] w_map_narrow;
    logic [63:0] w_enc_value;

    assign o_in_ready = i_q_ready && i_rst_n;
    assign o_push     = i_in_valid && o_in_ready;

    assign w_map_wide   = (i_in_data.value << 1) ^ {64{i_in_data.value[63]}};
    assign w_map_narrow = (i_in_data.value[31:0] << 1) ^ {32{i_in_data.value[31]}};

    always_comb begin
        if (i_in_data.wide) begin
            w_enc_value = i_in_data.zigzag ? w_map_wide : i_in_data.value;
        end else begin
            w_enc_value = {32'd0, i_in_data.zigzag ? w_map_narrow : i_in_data.value[31:0]};
        end
    end

    always_comb begin
        o_entry.op     = i_in_data.op;
        o_entry.wide   = i_in_data.wide;
        o_entry.zigzag = i_in_data.zigzag;
        case (i_in_data.op)
            OP_ENCODE: o_entry.data = w_enc_value;
            OP_DECODE: o_entry.data = {56'd0, i_in_data.in_byte};
            default:   o_entry.data = w_enc_value;
        endcase
    end

endmodule

// ----- hdl/vzz_queue.sv -----
// Short FIFO between front and back ends of the codec.
// Depends on vzz_pkg for the entry type and depth.
module vzz_queue
    import vzz_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_entry,
    output logic     o_ready,
    output logic     o_valid,
    output t_q_entry o_entry,
    input  logic     i_pop
);

    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_q_entry               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]     r_wr_ptr;
    logic [Q_PTR_W-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]       r_count;
    logic [Q_PTR_W-1:0]     n_wr_ptr;
    logic [Q_PTR_W-1:0]     n_rd_ptr;

    assign o_ready = (r_count != CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hdl/vzz_back.sv -----
// Back end: emits encoded bytes one per cycle when not stalled; accumulates decode bytes.
// Depends on vzz_pkg; drains vzz_queue into the output register.
module vzz_back
    import vzz_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_q_entry  i_q_entry,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // Output register
    logic        r_out_valid;
    t_out_item   r_out;
    // Encoder in progress
    logic        r_busy;
    logic [63:0] r_v;
    logic [3:0]  r_idx;
    logic        r_enc_wide;
    // Decoder state
    logic [63:0] r_acc;
    logic [3:0]  r_gi;
    logic        r_lw;
    logic        r_lz;

    logic        n_out_valid;
    t_out_item   n_out;
    logic        n_busy;
    logic [63:0] n_v;
    logic [3:0]  n_idx;
    logic        n_enc_wide;
    logic [63:0] n_acc;
    logic [3:0]  n_gi;
    logic        n_lw;
    logic        n_lz;

    logic        w_can_emit;
    logic [63:0] w_src_v;
    logic [3:0]  w_src_idx;
    logic        w_src_wide;
    logic        w_enc_last;
    logic [7:0]  w_enc_byte;

    logic        w_first;
    logic        w_eff_wide;
    logic        w_eff_zz;
    logic [5:0]  w_shamt;
    logic [63:0] w_acc_new;
    logic [63:0] w_zz;
    logic [63:0] w_dec_val;
    logic        w_dec_final;

    assign w_can_emit = !r_out_valid || i_out_ready;
    assign o_pop      = !r_busy && i_q_valid && w_can_emit;

    // Next byte of an encoding, from the running value or the queue head
    always_comb begin
        w_src_v    = r_busy ? r_v : i_q_entry.data;
        w_src_idx  = r_busy ? r_idx : 4'd0;
        w_src_wide = r_busy ? r_enc_wide : i_q_entry.wide;
        w_enc_last = (w_src_v[63:GROUP_BITS] == '0) ||
                     (w_src_idx == (w_src_wide ? LAST_IDX_WIDE : LAST_IDX_NARROW));
        w_enc_byte = w_enc_last ? w_src_v[7:0] : {1'b1, w_src_v[GROUP_BITS-1:0]};
    end

    // Decode step; width and mode come from the head at the first byte
    always_comb begin
        w_first    = (r_gi == 4'd0);
        w_eff_wide = w_first ? i_q_entry.wide : r_lw;
        w_eff_zz   = w_first ? i_q_entry.zigzag : r_lz;
        w_shamt    = {2'b00, r_gi} * 6'd7;
        w_acc_new  = (w_first ? 64'd0 : r_acc) |
                     ({57'd0, i_q_entry.data[GROUP_BITS-1:0]} << w_shamt);
        if (!w_eff_wide) begin
            w_acc_new[63:32] = 32'd0;
        end
        w_dec_final = !i_q_entry.data[7] ||
                      (r_gi == (w_eff_wide ? LAST_IDX_WIDE : LAST_IDX_NARROW));
        w_zz = (w_acc_new >> 1) ^ {64{w_acc_new[0]}};
        if (!w_eff_zz) begin
            w_dec_val = w_acc_new;
        end else if (w_eff_wide) begin
            w_dec_val = w_zz;
        end else begin
            w_dec_val = {{32{w_zz[31]}}, w_zz[31:0]};
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_busy      = r_busy;
        n_v         = r_v;
        n_idx       = r_idx;
        n_enc_wide  = r_enc_wide;
        n_acc       = r_acc;
        n_gi        = r_gi;
        n_lw        = r_lw;
        n_lz        = r_lz;
        if (w_can_emit) begin
            n_out_valid = 1'b0;
            if (r_busy || (i_q_valid && i_q_entry.op == OP_ENCODE)) begin
                n_out_valid         = 1'b1;
                n_out.kind          = KIND_BYTE;
                n_out.out_byte      = w_enc_byte;
                n_out.out_value     = 64'd0;
                n_out.last          = w_enc_last;
                n_busy              = !w_enc_last;
                n_v                 = w_src_v >> GROUP_BITS;
                n_idx               = w_src_idx + 4'd1;
                n_enc_wide          = w_src_wide;
            end else if (i_q_valid) begin
                n_lw = w_eff_wide;
                n_lz = w_eff_zz;
                if (w_dec_final) begin
                    n_out_valid     = 1'b1;
                    n_out.kind      = KIND_VALUE;
                    n_out.out_byte  = 8'd0;
                    n_out.out_value = w_dec_val;
                    n_out.last      = 1'b1;
                    n_acc           = 64'd0;
                    n_gi            = 4'd0;
                end else begin
                    n_acc = w_acc_new;
                    n_gi  = r_gi + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_busy      <= 1'b0;
            r_acc       <= 64'd0;
            r_gi        <= 4'd0;
            r_lw        <= 1'b0;
            r_lz        <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_busy      <= n_busy;
            r_acc       <= n_acc;
            r_gi        <= n_gi;
            r_lw        <= n_lw;
            r_lz        <= n_lz;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_v        <= n_v;
        r_idx      <= n_idx;
        r_enc_wide <= n_enc_wide;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hdl/vzz_checker.sv -----
// Port-level checks of the varint/zigzag codec, bound to the top level.
// Depends on vzz_pkg and varint_zigzag_codec_macros.svh.
`include "varint_zigzag_codec_macros.svh"

module vzz_checker
    import vzz_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    `VZZ_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "output changed while stalled")
    `VZZ_ASSERT(a_in_hold, i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data), "input changed while waiting")
    `VZZ_ASSERT(a_value_shape, o_out_valid && o_out_data.kind == KIND_VALUE |-> o_out_data.last && o_out_data.out_byte == 8'd0, "malformed value result")
    `VZZ_ASSERT(a_byte_shape, o_out_valid && o_out_data.kind == KIND_BYTE |-> o_out_data.out_byte[7] == !o_out_data.last && o_out_data.out_value == 64'd0, "continuation bit disagrees with last")
    `VZZ_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |-> !o_in_ready ##1 !o_out_valid, "activity during or right after reset")

endmodule

bind varint_zigzag_codec vzz_checker u_vzz_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
